FILE: src/cae_pkg.sv
package cae_pkg;

    typedef enum logic [1:0] {
        REG_COLUMN_COUNT = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_FIND_MINIMUM = 2'd2,
        REG_MATRIX_COUNT = 2'd3
    } reg_index_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned ROW_W   = 12;
    localparam int unsigned COL_W   = 8;
    localparam int unsigned MAT_W   = 16;

    typedef struct packed {
        logic             first_row;
        logic             last_row;
        logic             last_col;
        logic             last_mat;
        logic             find_min;
        logic [ROW_W-1:0] row;
    } step_ctrl_t;

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] k;
        if (b[30:0] == 31'd0)
            k = 32'h8000_0000;
        else if (b[31])
            k = ~b;
        else
            k = b | 32'h8000_0000;
        return k;
    endfunction

endpackage

FILE: src/cae_config.sv
module cae_config #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic [12:0] cols_eff,
    output logic [16:0] rows_eff,
    output logic [15:0] mats_eff,
    output logic        find_min
);
    logic [8:0]  column_count_reg;
    logic [12:0] row_count_reg;
    logic        find_minimum_reg;
    logic [15:0] matrix_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 9'd1;
            row_count_reg    <= 13'd1;
            find_minimum_reg <= 1'b0;
            matrix_count_reg <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cae_pkg::reg_index_t'(cfg_index))
                cae_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data[8:0];
                cae_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data[12:0];
                cae_pkg::REG_FIND_MINIMUM: find_minimum_reg <= cfg_data[0];
                cae_pkg::REG_MATRIX_COUNT: matrix_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (column_count_reg == 9'd0)
            cols_eff = 13'd1;
        else if ({4'd0, column_count_reg} > 13'(MAX_COLUMNS))
            cols_eff = 13'(MAX_COLUMNS);
        else
            cols_eff = {4'd0, column_count_reg};
        if (row_count_reg == 13'd0)
            rows_eff = 17'd1;
        else if ({4'd0, row_count_reg} > 17'(MAX_ROWS))
            rows_eff = 17'(MAX_ROWS);
        else
            rows_eff = {4'd0, row_count_reg};
        mats_eff = (matrix_count_reg == 16'd0) ? 16'd1 : matrix_count_reg;
    end

    assign find_min = find_minimum_reg;
endmodule

FILE: src/cae_sequencer.sv
module cae_sequencer #(
    parameter int COL_AW = 8,
    parameter int ROW_PW = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [12:0]       cols_eff,
    input  logic [16:0]       rows_eff,
    input  logic [15:0]       mats_eff,
    input  logic              find_min,
    output logic [COL_AW-1:0] slot,
    output cae_pkg::step_ctrl_t ctrl
);
    logic [COL_AW-1:0] col_reg;
    logic [ROW_PW-1:0] row_reg;
    logic [15:0]       mat_reg;
    logic [12:0]       col_ext;
    logic [12:0]       col_use;

    always_comb
    begin
        col_ext = 13'(col_reg);
        col_use = (col_ext >= cols_eff) ? cols_eff - 13'd1 : col_ext;
        slot = col_use[COL_AW-1:0];
        ctrl.last_col = (col_ext + 13'd1) >= cols_eff;
        ctrl.last_row = (17'(row_reg) + 17'd1) >= rows_eff;
        ctrl.last_mat = (17'(mat_reg) + 17'd1) >= 17'(mats_eff);
        ctrl.first_row = (row_reg == '0);
        ctrl.find_min = find_min;
        ctrl.row = cae_pkg::ROW_W'(row_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            mat_reg <= '0;
        end
        else if (advance)
        begin
            if (ctrl.last_col)
            begin
                col_reg <= '0;
                if (ctrl.last_row)
                begin
                    row_reg <= '0;
                    mat_reg <= ctrl.last_mat ? 16'd0 : mat_reg + 16'd1;
                end
                else
                    row_reg <= row_reg + 1'b1;
            end
            else
                col_reg <= slot + 1'b1;
        end
    end
endmodule

FILE: src/cae_column_store.sv
module cae_column_store #(
    parameter int DEPTH  = 256,
    parameter int COL_AW = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [31:0]                 element,
    input  logic [COL_AW-1:0]           slot,
    input  cae_pkg::step_ctrl_t         ctrl,
    output logic                        res_valid,
    output logic [31:0]                 res_bits,
    output logic [cae_pkg::ROW_W-1:0]   res_row,
    output logic [COL_AW-1:0]           res_slot,
    output logic                        res_mdone,
    output logic                        res_bdone,
    output logic [1:0]                  in_flight
);
    logic [31:0]               value_mem [DEPTH];
    logic [cae_pkg::ROW_W-1:0] row_mem [DEPTH];

    logic                      s1_valid_reg;
    logic [31:0]               s1_element_reg;
    logic [COL_AW-1:0]         s1_slot_reg;
    cae_pkg::step_ctrl_t       s1_ctrl_reg;
    logic [31:0]               rd_value_reg;
    logic [cae_pkg::ROW_W-1:0] rd_row_reg;
    logic                      fwd_sel_reg;
    logic [31:0]               fwd_value_reg;
    logic [cae_pkg::ROW_W-1:0] fwd_row_reg;

    logic                      fwd_hit;
    logic [31:0]               cur_value;
    logic [cae_pkg::ROW_W-1:0] cur_row;
    logic [31:0]               new_value;
    logic [cae_pkg::ROW_W-1:0] new_row;
    logic                      take;
    logic [31:0]               kv;
    logic [31:0]               kc;

    // word in the update stage writes the entry the incoming word reads
    assign fwd_hit   = s1_valid_reg && (s1_slot_reg == slot);
    assign cur_value = fwd_sel_reg ? fwd_value_reg : rd_value_reg;
    assign cur_row   = fwd_sel_reg ? fwd_row_reg : rd_row_reg;
    assign in_flight = {1'b0, s1_valid_reg && s1_ctrl_reg.last_row} + {1'b0, res_valid};

    always_comb
    begin
        kv = cae_pkg::order_key(s1_element_reg);
        kc = cae_pkg::order_key(cur_value);
        take = 1'b0;
        if (s1_ctrl_reg.first_row)
            take = 1'b1;
        else if (!cae_pkg::is_nan(s1_element_reg) && !cae_pkg::is_nan(cur_value))
            take = s1_ctrl_reg.find_min ? (kv < kc) : (kv > kc);
        new_value = take ? s1_element_reg : cur_value;
        if (s1_ctrl_reg.first_row)
            new_row = '0;
        else
            new_row = take ? s1_ctrl_reg.row : cur_row;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            value_mem[s1_slot_reg] <= new_value;
            row_mem[s1_slot_reg]   <= new_row;
        end
        if (in_fire)
        begin
            rd_value_reg <= value_mem[slot];
            rd_row_reg   <= row_mem[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_element_reg <= element;
            s1_slot_reg    <= slot;
            s1_ctrl_reg    <= ctrl;
            fwd_sel_reg    <= fwd_hit;
            fwd_value_reg  <= new_value;
            fwd_row_reg    <= new_row;
        end
        if (s1_valid_reg)
        begin
            res_bits  <= new_value;
            res_row   <= new_row;
            res_slot  <= s1_slot_reg;
            res_mdone <= s1_ctrl_reg.last_col;
            res_bdone <= s1_ctrl_reg.last_col && s1_ctrl_reg.last_mat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            res_valid    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            res_valid    <= s1_valid_reg && s1_ctrl_reg.last_row;
        end
    end
endmodule

FILE: src/cae_out_skid.sv
module cae_out_skid #(
    parameter int W = 54
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    input  logic [1:0]   in_flight,
    output logic         room,
    output logic         out_valid,
    output logic [W-1:0] out_data,
    input  logic         out_stall
);
    logic [W-1:0] word_mem [4];
    logic [1:0]   wr_ptr_reg;
    logic [1:0]   rd_ptr_reg;
    logic [2:0]   count_reg;
    logic         push;
    logic         pop;
    logic [2:0]   used;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = word_mem[rd_ptr_reg];
    assign push      = in_valid;
    assign pop       = out_valid && !out_stall;
    // words still in the pipeline must all fit
    assign used      = count_reg + {1'b0, in_flight};
    assign room      = (used < 3'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 3'd1;
                2'b01:   count_reg <= count_reg - 3'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            word_mem[wr_ptr_reg] <= in_data;
    end
endmodule

FILE: src/column_arg_extremum.sv
// an accepted word passes the update stage and the result registers into the output fifo
// throughput: one word per cycle unless in_stall is high; column store read and update
// are split over two stages with write forwarding between them
// input stalls only when the four-word output fifo could not take every result in flight
// rst_n asynchronous active low: counts back to 1, mode to max, positions to 0, fifo empty
// column stores are not cleared; row 0 of each matrix writes them first
module column_arg_extremum #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] element_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] best_bits,
    output logic [11:0] best_row,
    output logic [7:0]  column_index,
    output logic        matrix_done,
    output logic        batch_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_PW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int OUT_W  = 32 + 12 + 8 + 2;

    logic [12:0]         cols_eff;
    logic [16:0]         rows_eff;
    logic [15:0]         mats_eff;
    logic                find_min;
    logic [COL_AW-1:0]   slot;
    cae_pkg::step_ctrl_t ctrl;
    logic                in_fire;
    logic                room;
    logic                res_valid;
    logic [31:0]         res_bits;
    logic [11:0]         res_row;
    logic [COL_AW-1:0]   res_slot;
    logic                res_mdone;
    logic                res_bdone;
    logic [1:0]          in_flight;
    logic [OUT_W-1:0]    out_data;

    assign in_stall = !room;
    assign in_fire  = in_valid && room;

    cae_config #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_config (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .cols_eff, .rows_eff, .mats_eff, .find_min
    );

    cae_sequencer #(.COL_AW(COL_AW), .ROW_PW(ROW_PW)) u_seq (
        .clk, .rst_n, .advance(in_fire), .cols_eff, .rows_eff, .mats_eff,
        .find_min, .slot, .ctrl
    );

    cae_column_store #(.DEPTH(MAX_COLUMNS), .COL_AW(COL_AW)) u_store (
        .clk, .rst_n, .in_fire, .element(element_bits), .slot, .ctrl,
        .res_valid, .res_bits, .res_row, .res_slot, .res_mdone, .res_bdone,
        .in_flight
    );

    cae_out_skid #(.W(OUT_W)) u_skid (
        .clk, .rst_n, .in_valid(res_valid),
        .in_data({res_bits, res_row, 8'(res_slot), res_mdone, res_bdone}),
        .in_flight, .room, .out_valid, .out_data, .out_stall
    );

    assign {best_bits, best_row, column_index, matrix_done, batch_done} = out_data;

`ifndef SYNTHESIS
    a_bdone_implies_mdone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!batch_done || matrix_done))
        else $error("batch end without matrix end");
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");
    a_res_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(in_fire, 2))
        else $error("result without accepted word");
`endif
endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [31:0] best_bits;
        logic [11:0] best_row;
        logic [7:0]  column_index;
        logic        matrix_done;
        logic        batch_done;
    } column_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] element_bits = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] best_bits;
    logic [11:0] best_row;
    logic [7:0]  column_index;
    logic        matrix_done;
    logic        batch_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic [31:0]  pending_elements[$];
    column_word_t expected_columns[$];
    int           error_count = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           hold_go = 0;
    logic         hold_rx = 1'b0;

    // shadow copy of the block's registers and column store
    logic [8:0]  sh_cols = 9'd1;
    logic [12:0] sh_rows = 13'd1;
    logic        sh_min = 1'b0;
    logic [15:0] sh_mats = 16'd1;
    logic [31:0] sh_value[256];
    logic [11:0] sh_row[256];
    int unsigned sh_cpos = 0;
    int unsigned sh_rpos = 0;
    int unsigned sh_mpos = 0;

    column_arg_extremum u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .element_bits(element_bits),
        .out_valid(out_valid), .out_stall(out_stall),
        .best_bits(best_bits), .best_row(best_row), .column_index(column_index),
        .matrix_done(matrix_done), .batch_done(batch_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(12 * 600000);
        $display("FAIL");
        $finish;
    end

    function automatic bit float_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // unsigned key that orders non-NaN floats, both zeros equal
    function automatic logic [31:0] float_rank(input logic [31:0] b);
        if (b[30:0] == 31'd0)
            return 32'h8000_0000;
        if (b[31])
            return ~b;
        return b | 32'h8000_0000;
    endfunction

    function automatic int unsigned eff_cols();
        if (sh_cols == 0)
            return 1;
        return (sh_cols > 256) ? 256 : sh_cols;
    endfunction

    function automatic int unsigned eff_rows();
        if (sh_rows == 0)
            return 1;
        return (sh_rows > 4096) ? 4096 : sh_rows;
    endfunction

    function automatic int unsigned eff_mats();
        return (sh_mats == 0) ? 1 : sh_mats;
    endfunction

    task automatic track_column(input logic [31:0] v);
        int unsigned cols;
        int unsigned rows;
        int unsigned col;
        bit          last_col;
        bit          last_row;
        bit          take;
        column_word_t w;
        cols = eff_cols();
        rows = eff_rows();
        col = sh_cpos;
        last_col = (col + 1 >= cols);
        last_row = (sh_rpos + 1 >= rows);
        if (col >= cols)
            col = cols - 1;
        if (sh_rpos == 0)
        begin
            sh_value[col] = v;
            sh_row[col] = '0;
        end
        else
        begin
            take = 0;
            if (!float_is_nan(v) && !float_is_nan(sh_value[col]))
                take = sh_min ? (float_rank(v) < float_rank(sh_value[col]))
                              : (float_rank(v) > float_rank(sh_value[col]));
            if (take)
            begin
                sh_value[col] = v;
                sh_row[col] = sh_rpos[11:0];
            end
        end
        if (last_row)
        begin
            w.best_bits = sh_value[col];
            w.best_row = sh_row[col];
            w.column_index = col[7:0];
            w.matrix_done = last_col;
            w.batch_done = last_col && (sh_mpos + 1 >= eff_mats());
            expected_columns.push_back(w);
        end
        if (last_col)
        begin
            sh_cpos = 0;
            if (last_row)
            begin
                sh_rpos = 0;
                sh_mpos = (sh_mpos + 1 >= eff_mats()) ? 0 : sh_mpos + 1;
            end
            else
                sh_rpos++;
        end
        else
            sh_cpos = col + 1;
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) == 1, 31'd0};
            1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
            2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'(($urandom() | 1))};
            3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
            4: return {$urandom_range(0, 1) == 1, 8'd127, 20'd0, 3'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                track_column(element_bits);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_elements.size() > 0)
                begin
                    in_valid <= 1'b1;
                    element_bits <= pending_elements.pop_front();
                    send_gap = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        column_word_t w;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_columns.size() == 0)
                begin
                    $error("unexpected result word, column %0d", column_index);
                    error_count++;
                end
                else
                begin
                    w = expected_columns.pop_front();
                    if (best_bits !== w.best_bits)
                    begin
                        $error("best_bits expected %h got %h", w.best_bits, best_bits);
                        error_count++;
                    end
                    if (best_row !== w.best_row)
                    begin
                        $error("best_row expected %0d got %0d", w.best_row, best_row);
                        error_count++;
                    end
                    if (column_index !== w.column_index)
                    begin
                        $error("column_index expected %0d got %0d",
                               w.column_index, column_index);
                        error_count++;
                    end
                    if (matrix_done !== w.matrix_done)
                    begin
                        $error("matrix_done expected %b got %b", w.matrix_done, matrix_done);
                        error_count++;
                    end
                    if (batch_done !== w.batch_done)
                    begin
                        $error("batch_done expected %b got %b", w.batch_done, batch_done);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                recv_gap = draw_gap();
                out_stall <= hold_rx;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic write_reg(input cae_pkg::reg_index_t idx, input logic [15:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cae_pkg::REG_COLUMN_COUNT: sh_cols = d[8:0];
            cae_pkg::REG_ROW_COUNT:    sh_rows = d[12:0];
            cae_pkg::REG_FIND_MINIMUM: sh_min = d[0];
            cae_pkg::REG_MATRIX_COUNT: sh_mats = d;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_elements.size() > 0 || in_valid || expected_columns.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic setup(input logic [15:0] c, input logic [15:0] r,
                         input logic m, input logic [15:0] n);
        wait_idle();
        write_reg(cae_pkg::REG_COLUMN_COUNT, c);
        write_reg(cae_pkg::REG_ROW_COUNT, r);
        write_reg(cae_pkg::REG_FIND_MINIMUM, {15'd0, m});
        write_reg(cae_pkg::REG_MATRIX_COUNT, n);
    endtask

    task automatic queue_matrices(input int n);
        repeat (n * eff_cols() * eff_rows())
            pending_elements.push_back(random_element());
    endtask

    initial
    begin
        logic [31:0] probe[12];
        int          sent;
        int          k;
        probe = '{32'h0000_0000, 32'h7FC0_0000, 32'hFF80_0000, 32'h3F80_0000,
                  32'h8000_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF, 32'h4000_0000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // ties, zeros, infinities, stored and incoming nan in both modes
        for (int m = 0; m < 2; m++)
        begin
            setup(16'd4, 16'd3, m[0], 16'd1);
            foreach (probe[i])
                pending_elements.push_back(probe[i]);
        end

        // zero counts act as one
        setup(16'd0, 16'd0, 1'b0, 16'd0);
        queue_matrices(5);

        // widest row, column count clamped
        setup(16'd511, 16'd1, 1'b1, 16'd65535);
        queue_matrices(1);

        // tall matrix cut short by a smaller row count
        setup(16'd1, 16'd8191, 1'b0, 16'd2);
        repeat (40)
            pending_elements.push_back(random_element());
        setup(16'd1, 16'd2, 1'b0, 16'd2);
        pending_elements.push_back(random_element());

        // receiver holds off while the sender keeps going
        setup(16'd3, 16'd1, 1'b0, 16'd3);
        queue_matrices(50);
        hold_go = 1;

        sent = 0;
        while (sent < 300)
        begin
            setup(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(1, 4)));
            k = $urandom_range(1, 3);
            queue_matrices(k);
            sent += k * eff_cols() * eff_rows();
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
